### hdl/exlex_pkg.sv
// ----------------------------------------------------------------------------
// exlex_pkg
// types, token codes, character codes and keyword tables of the expression
// lexer
// ----------------------------------------------------------------------------
`default_nettype none

package exlex_pkg;

  localparam int LINE_LENGTH_DEFAULT = 256;

  // result queue between the scanner and the output port
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int NUM_KEYWORDS = 4;
  localparam logic [3:0] FRAC_MAX = 4'd9;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_INT     = 6'b000010,
    MODE_FRAC    = 6'b000100,
    MODE_IDENT   = 6'b001000,
    MODE_PEND    = 6'b010000,
    MODE_DISCARD = 6'b100000
  } scan_mode_e;

  typedef enum logic [4:0] {
    KIND_IF     = 5'd0,
    KIND_ELSE   = 5'd1,
    KIND_FOR    = 5'd2,
    KIND_WHILE  = 5'd3,
    KIND_ASSIGN = 5'd4,
    KIND_EQ     = 5'd5,
    KIND_LT     = 5'd6,
    KIND_GT     = 5'd7,
    KIND_LTE    = 5'd8,
    KIND_GTE    = 5'd9,
    KIND_NOTEQ  = 5'd10,
    KIND_NUMBER = 5'd11,
    KIND_IDENT  = 5'd12,
    KIND_ADD    = 5'd13,
    KIND_SUB    = 5'd14,
    KIND_MUL    = 5'd15,
    KIND_DIV    = 5'd16,
    KIND_LPAR   = 5'd17,
    KIND_RPAR   = 5'd18,
    KIND_SEMI   = 5'd19,
    KIND_END    = 5'd20,
    KIND_ERROR  = 5'd21
  } token_kind_e;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_LPAR  = 8'h28;
  localparam logic [7:0] CHAR_RPAR  = 8'h29;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

  localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{8'd2, 8'd4, 8'd3, 8'd5};

  typedef struct packed {
    token_kind_e  kind;
    logic [7:0]   start;
    logic [7:0]   len;
    logic [31:0]  int_part;
    logic [29:0]  frac_digits;
    logic [3:0]   frac_count;
    logic         last;
  } token_t;

  function automatic token_t make_token(input token_kind_e kind, input logic [7:0] start,
                                        input logic [7:0] len);
    token_t t;
    t = '0;
    t.kind = kind;
    t.start = start;
    t.len = len;
    return t;
  endfunction

  // keyword text, left justified
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [39:0] txt;
    logic [39:0] shifted;
    case (k)
      2'd0:    txt = {"if", 24'h0};
      2'd1:    txt = {"else", 8'h0};
      2'd2:    txt = {"for", 16'h0};
      default: txt = "while";
    endcase
    shifted = txt << {idx, 3'b000};
    return shifted[39:32];
  endfunction

  // keywords whose character at idx equals c
  function automatic logic [3:0] kw_hits(input logic [7:0] c, input logic [7:0] idx);
    logic [3:0] hit;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      hit[k] = (idx < KW_LEN[k]) && (kw_char(2'(k), idx[2:0]) == c);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### hdl/expression_lexer_core.sv
// ----------------------------------------------------------------------------
// expression_lexer_core
// streaming lexer: one character per input transaction, tokens out
// ----------------------------------------------------------------------------
// Characters of a line enter on the in channel, a zero byte ends the line.
// Each token leaves as one out transaction with kind, start position, length
// and, for numbers, integer part, fraction digits and fraction count; last
// marks the final token caused by one character.
// A character is scanned in the cycle it is accepted and its tokens are
// written into a four-entry result queue. One character is taken every
// cycle while in_ready_o is high; a character that closes a token and
// itself gives a one-character token or ends the line gives two tokens,
// which leave one after the other on the single out port. in_ready_o is
// high while the queue has room for two tokens, so a stalled receiver
// holds off the sender and nothing is lost.
// Reset empties the queue and puts the scanner at the start of a line.
// Positions stick at the smaller of LINE_LENGTH-1 and 255 on long lines.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_lexer_core
  import exlex_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  character_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       token_kind_o,
  output logic [7:0]       start_position_o,
  output logic [7:0]       token_length_o,
  output logic [31:0]      integer_part_o,
  output logic [29:0]      fraction_digits_o,
  output logic [3:0]       fraction_count_o,
  output logic             last_o
);

  localparam int PosMaxInt = ((LINE_LENGTH - 1) < 255) ? (LINE_LENGTH - 1) : 255;
  localparam logic [7:0] PosMax = 8'(PosMaxInt);

  scan_mode_e mode_q, mode_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] tstart_q, tstart_d;
  logic [7:0] tcnt_q, tcnt_d;
  logic [31:0] int_q, int_d;
  logic [29:0] frac_q, frac_d;
  logic [3:0] fcnt_q, fcnt_d;
  logic [7:0] pend_q, pend_d;
  logic [3:0] kw_q, kw_d;

  token_t fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] occ_q;

  logic in_fire, out_fire;
  logic [7:0] c;
  logic is_digit, is_alpha;
  logic [35:0] int_prod;
  logic [33:0] frac_prod;
  logic [31:0] int_next;
  logic [29:0] frac_next;
  logic [3:0] hit_cur, hit_first;
  token_kind_e ident_kind;
  token_t pre_tok, post_tok, r0, r1;
  logic pre_vld, post_vld, do_idle, line_done, consumed;
  logic [1:0] n_push;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign c = character_i;
  assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  assign is_alpha = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ||
                    ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z));

  // times ten plus digit, as shift and add
  assign int_prod  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + {32'b0, c[3:0]};
  assign int_next  = (|int_prod[35:32]) ? '1 : int_prod[31:0];
  assign frac_prod = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1) + {30'b0, c[3:0]};
  assign frac_next = frac_prod[29:0];

  assign hit_cur   = kw_hits(c, tcnt_q);
  assign hit_first = kw_hits(c, 8'd0);

  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (kw_q[k] && (tcnt_q == KW_LEN[k])) begin
        ident_kind = token_kind_e'(5'(k));
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    pos_d = pos_q;
    tstart_d = tstart_q;
    tcnt_d = tcnt_q;
    int_d = int_q;
    frac_d = frac_q;
    fcnt_d = fcnt_q;
    pend_d = pend_q;
    kw_d = kw_q;
    pre_tok = '0;
    pre_vld = 1'b0;
    post_tok = '0;
    post_vld = 1'b0;
    do_idle = 1'b0;
    line_done = 1'b0;
    consumed = 1'b0;
    if (in_fire) begin
      case (mode_q)
        MODE_INT: begin
          if (is_digit) begin
            int_d = int_next;
            consumed = 1'b1;
          end else if (c == CHAR_DOT) begin
            mode_d = MODE_FRAC;
            consumed = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            consumed = 1'b1;
            if (fcnt_q < FRAC_MAX) begin
              frac_d = frac_next;
              fcnt_d = fcnt_q + 4'd1;
            end
          end
        end
        MODE_IDENT: begin
          if (is_alpha || is_digit || c == CHAR_UNDER) begin
            kw_d = kw_q & hit_cur;
            consumed = 1'b1;
          end
        end
        default: ;
      endcase

      if (consumed) begin
        if (tcnt_q != COUNT_MAX) begin
          tcnt_d = tcnt_q + 8'd1;
        end
      end else begin
        case (mode_q)
          MODE_INT, MODE_FRAC: begin
            pre_tok = make_token(KIND_NUMBER, tstart_q, tcnt_q);
            pre_tok.int_part = int_q;
            pre_tok.frac_digits = frac_q;
            pre_tok.frac_count = fcnt_q;
            pre_vld = 1'b1;
            mode_d = MODE_IDLE;
            do_idle = 1'b1;
          end
          MODE_IDENT: begin
            pre_tok = make_token(ident_kind, tstart_q, tcnt_q);
            pre_vld = 1'b1;
            mode_d = MODE_IDLE;
            do_idle = 1'b1;
          end
          MODE_PEND: begin
            mode_d = MODE_IDLE;
            pend_d = '0;
            pre_vld = 1'b1;
            if (c == CHAR_EQ) begin
              case (pend_q)
                CHAR_LT: pre_tok = make_token(KIND_LTE, tstart_q, 8'd2);
                CHAR_GT: pre_tok = make_token(KIND_GTE, tstart_q, 8'd2);
                CHAR_EQ: pre_tok = make_token(KIND_EQ, tstart_q, 8'd2);
                default: pre_tok = make_token(KIND_NOTEQ, tstart_q, 8'd2);
              endcase
            end else if (pend_q == CHAR_BANG) begin
              pre_tok = make_token(KIND_ERROR, tstart_q, 8'd1);
              mode_d = MODE_DISCARD;
              if (c == CHAR_NUL) begin
                post_tok = make_token(KIND_END, pos_q, 8'd0);
                post_vld = 1'b1;
                line_done = 1'b1;
              end
            end else begin
              case (pend_q)
                CHAR_LT: pre_tok = make_token(KIND_LT, tstart_q, 8'd1);
                CHAR_GT: pre_tok = make_token(KIND_GT, tstart_q, 8'd1);
                default: pre_tok = make_token(KIND_ASSIGN, tstart_q, 8'd1);
              endcase
              do_idle = 1'b1;
            end
          end
          MODE_DISCARD: begin
            if (c == CHAR_NUL) begin
              post_tok = make_token(KIND_END, pos_q, 8'd0);
              post_vld = 1'b1;
              line_done = 1'b1;
            end
          end
          default: begin
            mode_d = MODE_IDLE;
            do_idle = 1'b1;
          end
        endcase
      end

      // character at the start of a token
      if (do_idle) begin
        if (c == CHAR_NUL) begin
          post_tok = make_token(KIND_END, pos_q, 8'd0);
          post_vld = 1'b1;
          line_done = 1'b1;
        end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
          mode_d = MODE_IDLE;
        end else if (is_digit) begin
          mode_d = MODE_INT;
          tstart_d = pos_q;
          tcnt_d = 8'd1;
          int_d = {28'b0, c[3:0]};
          frac_d = '0;
          fcnt_d = '0;
        end else if (is_alpha) begin
          mode_d = MODE_IDENT;
          tstart_d = pos_q;
          tcnt_d = 8'd1;
          kw_d = hit_first;
        end else begin
          post_vld = 1'b1;
          case (c)
            CHAR_LT, CHAR_GT, CHAR_EQ, CHAR_BANG: begin
              post_vld = 1'b0;
              mode_d = MODE_PEND;
              pend_d = c;
              tstart_d = pos_q;
              tcnt_d = 8'd1;
            end
            CHAR_PLUS:  post_tok = make_token(KIND_ADD, pos_q, 8'd1);
            CHAR_MINUS: post_tok = make_token(KIND_SUB, pos_q, 8'd1);
            CHAR_STAR:  post_tok = make_token(KIND_MUL, pos_q, 8'd1);
            CHAR_SLASH: post_tok = make_token(KIND_DIV, pos_q, 8'd1);
            CHAR_LPAR:  post_tok = make_token(KIND_LPAR, pos_q, 8'd1);
            CHAR_RPAR:  post_tok = make_token(KIND_RPAR, pos_q, 8'd1);
            CHAR_SEMI:  post_tok = make_token(KIND_SEMI, pos_q, 8'd1);
            default: begin
              post_tok = make_token(KIND_ERROR, pos_q, 8'd1);
              mode_d = MODE_DISCARD;
            end
          endcase
        end
      end

      if (line_done) begin
        mode_d = MODE_IDLE;
        pos_d = '0;
        tstart_d = '0;
        tcnt_d = '0;
        pend_d = '0;
        kw_d = '1;
      end else if (pos_q < PosMax) begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  // order the tokens of this character and flag the final one
  always_comb begin
    r0 = pre_vld ? pre_tok : post_tok;
    r1 = post_tok;
    r0.last = !(pre_vld && post_vld);
    r1.last = 1'b1;
    n_push = {1'b0, pre_vld} + {1'b0, post_vld};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q <= '0;
      tstart_q <= '0;
      tcnt_q <= '0;
      int_q <= '0;
      frac_q <= '0;
      fcnt_q <= '0;
      pend_q <= '0;
      kw_q <= '1;
      wr_q <= '0;
      rd_q <= '0;
      occ_q <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q <= pos_d;
      tstart_q <= tstart_d;
      tcnt_q <= tcnt_d;
      int_q <= int_d;
      frac_q <= frac_d;
      fcnt_q <= fcnt_d;
      pend_q <= pend_d;
      kw_q <= kw_d;
      wr_q <= wr_q + FIFO_PTR_W'(n_push);
      rd_q <= rd_q + FIFO_PTR_W'(out_fire);
      occ_q <= occ_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_q + FIFO_PTR_W'(1)] <= r1;
    end
  end

  assign in_ready_o = occ_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = occ_q != '0;

  assign token_kind_o      = fifo_q[rd_q].kind;
  assign start_position_o  = fifo_q[rd_q].start;
  assign token_length_o    = fifo_q[rd_q].len;
  assign integer_part_o    = fifo_q[rd_q].int_part;
  assign fraction_digits_o = fifo_q[rd_q].frac_digits;
  assign fraction_count_o  = fifo_q[rd_q].frac_count;
  assign last_o            = fifo_q[rd_q].last;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_nul_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && character_i == CHAR_NUL |-> n_push != 2'd0)
    else $error("end of line gave no token");

  a_nul_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && character_i == CHAR_NUL |=> pos_q == '0 && mode_q == MODE_IDLE)
    else $error("line state not cleared after end of line");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_q == MODE_DISCARD && character_i != CHAR_NUL |-> n_push == 2'd0)
    else $error("token emitted while discarding");
`endif

endmodule

`default_nettype wire
